// ===== src/apd_pkg.sv =====
package apd_pkg;

    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LEVEL_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_RATE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAX_GATE  = 3'd4;

    localparam logic [REG_W-1:0] AVG_RATE_RST        = 16'd655;
    localparam logic [REG_W-1:0] THRESHOLD_FLOOR_RST = 16'd3277;
    localparam logic [REG_W-1:0] REFRACTORY_RST      = 16'd0;
    localparam logic [REG_W-1:0] PEAK_LIMIT_RST      = 16'd32;
    localparam logic             LOCAL_MAX_GATE_RST  = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] avg_rate;
        logic [REG_W-1:0] threshold_floor;
        logic [REG_W-1:0] refractory_samples;
        logic [REG_W-1:0] peak_limit;
        logic             local_max_gate;
    } t_cfg;

    typedef struct packed {
        logic               qualify;
        logic [LEVEL_W-1:0] m31;
    } t_det_req;

endpackage

// ===== src/apd_if.sv =====
interface apd_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_buffer;

    modport source (output valid, sample, start_of_buffer, input ready);
    modport sink (input valid, sample, start_of_buffer, output ready);
endinterface

interface apd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        peak_found;
    logic [apd_pkg::REG_W-1:0]   peak_position;
    logic [apd_pkg::REG_W-1:0]   peak_total;

    modport source (output valid, peak_found, peak_position, peak_total, input ready);
    modport sink (input valid, peak_found, peak_position, peak_total, output ready);
endinterface

interface apd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [apd_pkg::CFG_IDX_W-1:0] index;
    logic [apd_pkg::REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/apd_core.sv =====
module apd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apd_pkg::t_cfg     i_cfg,
    input  apd_pkg::t_det_req i_req,
    output logic              o_detected
);

    logic [apd_pkg::LEVEL_W-1:0] r_avg_level;
    logic [apd_pkg::LEVEL_W-1:0] n_avg_level;
    logic [apd_pkg::LEVEL_W-1:0] avg_new;
    logic [apd_pkg::REG_W-1:0]   r_dead;
    logic [apd_pkg::REG_W-1:0]   n_dead;
    logic [apd_pkg::REG_W-1:0]   dead_dec;
    logic signed [32:0]          diff;
    logic signed [49:0]          prod;
    logic signed [49:0]          rounded;
    logic signed [49:0]          avg_sum;
    logic [33:0]                 lhs;
    logic [33:0]                 rhs;
    logic                        over_avg;
    logic                        over_floor;
    logic                        hit;

    // avg' = avg + round(alpha * (m31 - avg)), one signed multiply
    always_comb begin
        dead_dec   = (r_dead != '0) ? r_dead - 16'd1 : r_dead;
        diff       = $signed({1'b0, i_req.m31}) - $signed({1'b0, r_avg_level});
        prod       = 50'($signed({1'b0, i_cfg.avg_rate})) * 50'(diff);
        rounded    = prod + 50'sd32768;
        avg_sum    = $signed({18'b0, r_avg_level}) + (rounded >>> 16);
        avg_new    = avg_sum[31:0];
        lhs        = {1'b0, i_req.m31, 1'b0};
        rhs        = {2'b0, avg_new} + {1'b0, avg_new, 1'b0};
        over_avg   = lhs > rhs;
        over_floor = i_req.m31 > {i_cfg.threshold_floor, 16'b0};
        hit        = over_avg && over_floor && (dead_dec == '0);

        n_avg_level = r_avg_level;
        n_dead      = r_dead;
        if (i_req.qualify) begin
            n_avg_level = avg_new;
            n_dead      = hit ? i_cfg.refractory_samples : dead_dec;
        end
        o_detected = i_req.qualify && hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_level <= '0;
            r_dead      <= '0;
        end else begin
            r_avg_level <= n_avg_level;
            r_dead      <= n_dead;
        end
    end

endmodule

// ===== src/adaptive_peak_detector_top.sv =====
// adaptive peak detector
// i_in carries one sample request per handshake (sample, start_of_buffer);
// o_out returns exactly one result request for each sample, in order:
// peak_found, peak_position (index in the buffer) and peak_total.
// i_cfg writes one register per handshake (index, data); it is always ready
// and should only be used while no sample is in flight.
// a sample taken at a clock edge sits in the input register, is processed
// from there and its result is offered from the edge at which it advances
// into the result register. one sample is accepted every cycle while o_out is not stalled;
// the running average and refractory counter update as the sample advances, in gated mode only for a local maximum.
// in gated mode a peak is reported one sample late, with the index of the
// earlier sample. if o_out stalls, the result register holds and one more
// sample is buffered in the input register before i_in.ready drops.
// reset clears the average, counter, neighbor history, position and count,
// and loads the register defaults (alpha 655, floor 3277, dead time 0,
// at most 32 peaks, local max gate on).
module adaptive_peak_detector_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    apd_in_if.sink           i_in,
    apd_out_if.source        o_out,
    apd_cfg_if.sink          i_cfg
);

    localparam int POS_W = apd_pkg::REG_W;

    apd_pkg::t_cfg                 r_cfg;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_sob;
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [POS_W-1:0]              r_out_pos;
    logic [POS_W-1:0]              r_out_total;
    logic signed [SAMPLE_BITS-1:0] r_last;
    logic signed [SAMPLE_BITS-1:0] r_second;
    logic [1:0]                    r_hist_fill;
    logic [POS_W-1:0]              r_pos;
    logic [POS_W-1:0]              r_count;

    logic                          advance;
    logic [POS_W-1:0]              pos_eff;
    logic [POS_W-1:0]              count_eff;
    logic [1:0]                    fill_eff;
    logic signed [SAMPLE_BITS-1:0] cand;
    logic [SAMPLE_BITS-1:0]        mag;
    logic                          qualify;
    logic                          detected;
    logic                          found;
    logic [POS_W-1:0]              peak_pos;
    logic [POS_W-1:0]              n_count;
    logic [1:0]                    n_hist_fill;
    apd_pkg::t_det_req             det_req;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.peak_found    = r_out_found;
    assign o_out.peak_position = r_out_pos;
    assign o_out.peak_total    = r_out_total;

    always_comb begin
        pos_eff   = r_in_sob ? '0 : r_pos;
        count_eff = r_in_sob ? '0 : r_count;
        fill_eff  = r_in_sob ? 2'd0 : r_hist_fill;

        if (r_cfg.local_max_gate) begin
            cand     = r_last;
            qualify  = (fill_eff == 2'd2) && (r_last > r_second) && (r_last > r_in_sample);
            peak_pos = pos_eff - POS_W'(1);
        end else begin
            cand     = r_in_sample;
            qualify  = 1'b1;
            peak_pos = pos_eff;
        end

        // most negative value maps to 2^(SAMPLE_BITS-1), still fits unsigned
        mag = cand[SAMPLE_BITS-1] ? $unsigned(-cand) : $unsigned(cand);

        det_req.qualify = advance && qualify;
        det_req.m31     = apd_pkg::LEVEL_W'(mag) << (apd_pkg::LEVEL_W - SAMPLE_BITS);

        found       = detected && (count_eff < r_cfg.peak_limit);
        n_count     = count_eff + POS_W'(found);
        n_hist_fill = (fill_eff == 2'd2) ? fill_eff : fill_eff + 2'd1;
    end

    apd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_req      (det_req),
        .o_detected (detected)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avg_rate           <= apd_pkg::AVG_RATE_RST;
            r_cfg.threshold_floor    <= apd_pkg::THRESHOLD_FLOOR_RST;
            r_cfg.refractory_samples <= apd_pkg::REFRACTORY_RST;
            r_cfg.peak_limit         <= apd_pkg::PEAK_LIMIT_RST;
            r_cfg.local_max_gate     <= apd_pkg::LOCAL_MAX_GATE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                apd_pkg::CFG_AVG_RATE:        r_cfg.avg_rate           <= i_cfg.data;
                apd_pkg::CFG_THRESHOLD_FLOOR: r_cfg.threshold_floor    <= i_cfg.data;
                apd_pkg::CFG_REFRACTORY:      r_cfg.refractory_samples <= i_cfg.data;
                apd_pkg::CFG_PEAK_LIMIT:      r_cfg.peak_limit         <= i_cfg.data;
                apd_pkg::CFG_LOCAL_MAX_GATE:  r_cfg.local_max_gate     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_second    <= '0;
            r_hist_fill <= 2'd0;
            r_pos       <= '0;
            r_count     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_second    <= r_last;
                r_last      <= r_in_sample;
                r_hist_fill <= n_hist_fill;
                r_pos       <= pos_eff + POS_W'(1);
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_sample <= i_in.sample;
            r_in_sob    <= i_in.start_of_buffer;
        end
        if (advance) begin
            r_out_found <= found;
            r_out_pos   <= found ? peak_pos : '0;
            r_out_total <= n_count;
        end
    end

    a_found_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.peak_found |-> o_out.peak_total != '0)
        else $error("reported peak with zero total");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist_fill != 2'd3)
        else $error("history fill out of range");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_pos == $past(pos_eff) + POS_W'(1))
        else $error("position did not advance");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid && r_out_total == $past(n_count))
        else $error("result register not loaded");

endmodule
